// File: rtl/li_chao_distance_penalty_dp_defines.svh
// Assertion macros used by the block's datapath module
`ifndef LI_CHAO_DISTANCE_PENALTY_DP_DEFINES_SVH
`define LI_CHAO_DISTANCE_PENALTY_DP_DEFINES_SVH

// Same-cycle implication
`define LCDP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcdp: implication violated");

// Next-cycle implication
`define LCDP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcdp: next-cycle implication violated");

`endif

// File: rtl/lcdp_pkg.sv
`timescale 1ns / 1ps
package lcdp_pkg;

    localparam int LEAVES    = 1024;
    localparam int NODES     = 4 * LEAVES;
    localparam int LW        = $clog2(LEAVES);
    localparam int NW        = LW + 1;
    localparam int NODE_AW   = $clog2(NODES);
    localparam int KW        = NODE_AW + 1;
    localparam int CFG_W     = 11;
    localparam int STK_DEPTH = LW + 2;
    localparam int STK_AW    = $clog2(STK_DEPTH);
    localparam int SPW       = $clog2(STK_DEPTH + 1);

    localparam logic [1:0]  ACT_LOAD  = 2'd0;
    localparam logic [1:0]  ACT_ITEM  = 2'd1;
    localparam logic [1:0]  ACT_CLEAR = 2'd2;
    localparam logic [63:0] MOST_NEG  = 64'h8000_0000_0000_0000;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_Q_RD, S_Q_MUL, S_Q_ADD, S_FIN, S_WX, S_I_NODE,
        S_C1, S_C2, S_C3, S_E_MO, S_E_MN, S_E_CMP, S_I_DEC, S_POP
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD, CMD_ITEM, CMD_CLR_GO, CMD_CLEAR, CMD_Q_MUL, CMD_Q_ADD,
        CMD_FIN, CMD_WX, CMD_I_NODE, CMD_C1, CMD_C2, CMD_C3, CMD_E_MO, CMD_E_MN,
        CMD_E_CMP, CMD_I_DEC, CMD_POP
    } t_cmd;

    // outcome of the line comparison at a fully covered node
    typedef enum logic [2:0] {
        DEC_KEEP, DEC_REPLACE, DEC_RIGHT, DEC_RIGHT_SWAP, DEC_LEFT, DEC_LEFT_SWAP,
        DEC_STOP, DEC_SPLIT
    } t_dec;

    typedef struct packed {
        logic q_more;
        logic ins_skip;
        logic ins_cover;
        logic ins_leaf;
        t_dec dec;
        logic stk_empty;
        logic pass1;
        logic clr_last;
        logic pt_last;
    } t_stat;

    typedef struct packed {
        logic [KW-1:0] k;
        logic [LW-1:0] l;
        logic [LW-1:0] r;
        logic [31:0]   s;
        logic [63:0]   i;
    } t_frame;

    function automatic logic sge(input logic [63:0] a, input logic [63:0] b);
        return $signed(a) >= $signed(b);
    endfunction

    function automatic logic sle(input logic [63:0] a, input logic [63:0] b);
        return $signed(a) <= $signed(b);
    endfunction

endpackage

// File: rtl/lcdp_ctrl.sv
`timescale 1ns / 1ps
module lcdp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_action,
    input  lcdp_pkg::t_stat   i_stat,
    output lcdp_pkg::t_cmd    o_cmd,
    output logic              o_busy
);

    lcdp_pkg::t_state r_state, n_state;

    // state register; reset starts with the tree clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcdp_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = lcdp_pkg::CMD_NONE;
        o_busy  = 1'b1;
        case (r_state)
            lcdp_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    case (i_action)
                        lcdp_pkg::ACT_LOAD: begin
                            o_cmd = lcdp_pkg::CMD_LOAD;
                        end
                        lcdp_pkg::ACT_ITEM: begin
                            o_cmd   = lcdp_pkg::CMD_ITEM;
                            n_state = lcdp_pkg::S_Q_RD;
                        end
                        lcdp_pkg::ACT_CLEAR: begin
                            o_cmd   = lcdp_pkg::CMD_CLR_GO;
                            n_state = lcdp_pkg::S_CLEAR;
                        end
                        default: begin
                            o_cmd = lcdp_pkg::CMD_NONE;
                        end
                    endcase
                end
            end
            lcdp_pkg::S_CLEAR: begin
                o_cmd = lcdp_pkg::CMD_CLEAR;
                if (i_stat.clr_last) n_state = lcdp_pkg::S_IDLE;
            end
            lcdp_pkg::S_Q_RD: begin
                n_state = lcdp_pkg::S_Q_MUL;
            end
            lcdp_pkg::S_Q_MUL: begin
                o_cmd   = lcdp_pkg::CMD_Q_MUL;
                n_state = lcdp_pkg::S_Q_ADD;
            end
            lcdp_pkg::S_Q_ADD: begin
                o_cmd   = lcdp_pkg::CMD_Q_ADD;
                n_state = i_stat.q_more ? lcdp_pkg::S_Q_RD : lcdp_pkg::S_FIN;
            end
            lcdp_pkg::S_FIN: begin
                o_cmd   = lcdp_pkg::CMD_FIN;
                n_state = lcdp_pkg::S_WX;
            end
            lcdp_pkg::S_WX: begin
                o_cmd   = lcdp_pkg::CMD_WX;
                n_state = lcdp_pkg::S_I_NODE;
            end
            lcdp_pkg::S_I_NODE: begin
                o_cmd = lcdp_pkg::CMD_I_NODE;
                if (i_stat.ins_skip) begin
                    n_state = lcdp_pkg::S_POP;
                end else if (i_stat.ins_cover) begin
                    n_state = lcdp_pkg::S_C1;
                end else if (i_stat.ins_leaf) begin
                    n_state = lcdp_pkg::S_POP;
                end
            end
            lcdp_pkg::S_C1: begin
                o_cmd   = lcdp_pkg::CMD_C1;
                n_state = lcdp_pkg::S_C2;
            end
            lcdp_pkg::S_C2: begin
                o_cmd   = lcdp_pkg::CMD_C2;
                n_state = lcdp_pkg::S_C3;
            end
            lcdp_pkg::S_C3: begin
                o_cmd   = lcdp_pkg::CMD_C3;
                n_state = lcdp_pkg::S_E_MO;
            end
            lcdp_pkg::S_E_MO: begin
                o_cmd   = lcdp_pkg::CMD_E_MO;
                n_state = lcdp_pkg::S_E_MN;
            end
            lcdp_pkg::S_E_MN: begin
                o_cmd   = lcdp_pkg::CMD_E_MN;
                n_state = lcdp_pkg::S_E_CMP;
            end
            lcdp_pkg::S_E_CMP: begin
                o_cmd   = lcdp_pkg::CMD_E_CMP;
                n_state = i_stat.pt_last ? lcdp_pkg::S_I_DEC : lcdp_pkg::S_E_MO;
            end
            lcdp_pkg::S_I_DEC: begin
                o_cmd = lcdp_pkg::CMD_I_DEC;
                if (i_stat.dec == lcdp_pkg::DEC_KEEP || i_stat.dec == lcdp_pkg::DEC_REPLACE ||
                    i_stat.dec == lcdp_pkg::DEC_STOP) begin
                    n_state = lcdp_pkg::S_POP;
                end else begin
                    n_state = lcdp_pkg::S_I_NODE;
                end
            end
            lcdp_pkg::S_POP: begin
                o_cmd = lcdp_pkg::CMD_POP;
                if (i_stat.stk_empty && i_stat.pass1) begin
                    n_state = lcdp_pkg::S_IDLE;
                end else begin
                    n_state = lcdp_pkg::S_I_NODE;
                end
            end
            default: begin
                n_state = lcdp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/lcdp_dpath.sv
`timescale 1ns / 1ps
`include "li_chao_distance_penalty_dp_defines.svh"
module lcdp_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lcdp_pkg::t_cmd                i_cmd,
    input  logic [lcdp_pkg::LW-1:0]       i_slot,
    input  logic signed [31:0]            i_sorted_coordinate,
    input  logic signed [31:0]            i_position,
    input  logic [30:0]                   i_weight,
    input  logic signed [31:0]            i_bonus,
    input  logic [lcdp_pkg::LW-1:0]       i_rank,
    input  logic                          i_cfg_valid,
    input  logic [lcdp_pkg::CFG_W-1:0]    i_cfg_data,
    output lcdp_pkg::t_stat               o_stat,
    output logic                          o_valid,
    output logic signed [63:0]            o_dp_value,
    output logic signed [63:0]            o_best_so_far
);

    localparam int LW  = lcdp_pkg::LW;
    localparam int NW  = lcdp_pkg::NW;
    localparam int KW  = lcdp_pkg::KW;
    localparam int NAW = lcdp_pkg::NODE_AW;
    localparam int SPW = lcdp_pkg::SPW;
    localparam int SAW = lcdp_pkg::STK_AW;

    // config and item registers
    logic [lcdp_pkg::CFG_W-1:0] r_cfg;
    logic [31:0]   r_x;
    logic [30:0]   r_w;
    logic [31:0]   r_bonus;
    logic [LW-1:0] r_rank;
    logic [NW-1:0] r_n;

    // current node / frame
    logic [KW-1:0] r_k;
    logic [LW-1:0] r_l, r_r, r_i, r_j;
    logic [31:0]   r_ls;
    logic [63:0]   r_li;
    logic          r_pass;

    // arithmetic
    logic [63:0] r_best, r_prod, r_oval, r_dp, r_wx, r_rbest;
    logic [31:0] r_os;
    logic [63:0] r_oi;
    logic [31:0] r_xp [4];
    logic [3:0]  r_ge, r_le;
    logic [1:0]  r_pt;
    logic        r_ovalid;
    logic [NAW-1:0] r_clr;

    // memories
    logic [31:0] m_coord [lcdp_pkg::LEAVES];
    logic [31:0] m_ns    [lcdp_pkg::NODES];
    logic [63:0] m_ni    [lcdp_pkg::NODES];
    logic [31:0] r_ca, r_cb, r_nd_s;
    logic [63:0] r_nd_i;
    logic        r_ca_oob, r_cb_oob;

    // insert stack
    lcdp_pkg::t_frame r_stk [lcdp_pkg::STK_DEPTH];
    logic [SPW-1:0]   r_sp;

    logic [NW-1:0]  n_size, ca, cb, mid_p1;
    logic [LW:0]    mid_sum;
    logic [LW-1:0]  mid, rank_sat;
    logic [KW-1:0]  k2, k2p1, q_next_k;
    logic signed [31:0] m_a, m_b;
    logic signed [63:0] m_p;
    logic [63:0] q_v, n_nval, n_dp;
    logic [31:0] xa, xb;
    logic        node_we;
    logic [NAW-1:0] node_wa;
    logic [SPW-1:0] sp_m1;
    lcdp_pkg::t_dec dec;
    lcdp_pkg::t_frame push_f, pop_f;

    // saturated leaf count and rank
    always_comb begin
        if (r_cfg == '0) begin
            n_size = NW'(1);
        end else if (r_cfg > lcdp_pkg::CFG_W'(lcdp_pkg::LEAVES)) begin
            n_size = NW'(lcdp_pkg::LEAVES);
        end else begin
            n_size = NW'(r_cfg);
        end
        if ({1'b0, i_rank} >= n_size) rank_sat = LW'(n_size - NW'(1));
        else                          rank_sat = i_rank;
    end

    // tree geometry
    assign mid_sum = {1'b0, r_l} + {1'b0, r_r};
    assign mid     = mid_sum[LW:1];
    assign mid_p1  = {1'b0, mid} + NW'(1);
    assign k2      = {r_k[KW-2:0], 1'b0};
    assign k2p1    = {r_k[KW-2:0], 1'b1};
    assign q_next_k = (r_rank <= mid) ? k2 : k2p1;

    // shared multiplier
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_cmd)
            lcdp_pkg::CMD_Q_MUL: begin m_a = r_nd_s;            m_b = r_x;         end
            lcdp_pkg::CMD_FIN:   begin m_a = {1'b0, r_w};       m_b = r_x;         end
            lcdp_pkg::CMD_E_MO:  begin m_a = r_os;              m_b = r_xp[r_pt];  end
            lcdp_pkg::CMD_E_MN:  begin m_a = r_ls;              m_b = r_xp[r_pt];  end
            default:             begin m_a = '0;                m_b = '0;          end
        endcase
    end
    assign m_p = m_a * m_b;

    assign q_v    = r_prod + r_nd_i;
    assign n_nval = r_prod + r_li;
    assign n_dp   = r_best + {{32{r_bonus[31]}}, r_bonus};
    assign xa     = r_ca_oob ? 32'd0 : r_ca;
    assign xb     = r_cb_oob ? 32'd0 : r_cb;

    // decision at a covered node; bits: 0 left end, 1 mid, 2 mid+1, 3 right end
    always_comb begin
        if (r_ge[0] && r_ge[3])      dec = lcdp_pkg::DEC_KEEP;
        else if (r_le[0] && r_le[3]) dec = lcdp_pkg::DEC_REPLACE;
        else if (r_ge[0] && r_ge[1]) dec = lcdp_pkg::DEC_RIGHT;
        else if (r_le[0] && r_le[1]) dec = lcdp_pkg::DEC_RIGHT_SWAP;
        else if (r_ge[2] && r_ge[3]) dec = lcdp_pkg::DEC_LEFT;
        else if (r_le[2] && r_le[3]) dec = lcdp_pkg::DEC_LEFT_SWAP;
        else if (r_l == r_r)         dec = lcdp_pkg::DEC_STOP;
        else                         dec = lcdp_pkg::DEC_SPLIT;
    end

    // status to the controller
    always_comb begin
        o_stat.q_more    = (r_l < r_r) && (q_next_k < KW'(lcdp_pkg::NODES));
        o_stat.ins_skip  = (r_k >= KW'(lcdp_pkg::NODES)) || (r_l > r_j) || (r_r < r_i);
        o_stat.ins_cover = (r_i <= r_l) && (r_r <= r_j);
        o_stat.ins_leaf  = (r_l == r_r);
        o_stat.dec       = dec;
        o_stat.stk_empty = (r_sp == '0);
        o_stat.pass1     = r_pass;
        o_stat.clr_last  = (r_clr == '1);
        o_stat.pt_last   = (r_pt == 2'd3);
    end

    // stack frames
    assign sp_m1  = r_sp - SPW'(1);
    assign pop_f  = r_stk[sp_m1[SAW-1:0]];
    assign push_f = '{k: k2p1, l: mid_p1[LW-1:0], r: r_r, s: r_ls, i: r_li};

    // coordinate table: one write port, two registered read ports
    always_comb begin
        ca = {1'b0, r_l};
        cb = {1'b0, mid};
        if (i_cmd == lcdp_pkg::CMD_C2) begin
            ca = mid_p1;
            cb = {1'b0, r_r};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == lcdp_pkg::CMD_LOAD) m_coord[i_slot] <= i_sorted_coordinate;
        r_ca     <= m_coord[ca[LW-1:0]];
        r_cb     <= m_coord[cb[LW-1:0]];
        r_ca_oob <= ca[LW];
        r_cb_oob <= cb[LW];
    end

    // node line store
    assign node_we = (i_cmd == lcdp_pkg::CMD_CLEAR) ||
                     ((i_cmd == lcdp_pkg::CMD_I_DEC) &&
                      (dec == lcdp_pkg::DEC_REPLACE || dec == lcdp_pkg::DEC_RIGHT_SWAP ||
                       dec == lcdp_pkg::DEC_LEFT_SWAP));
    assign node_wa = (i_cmd == lcdp_pkg::CMD_CLEAR) ? r_clr : r_k[NAW-1:0];

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            m_ns[node_wa] <= (i_cmd == lcdp_pkg::CMD_CLEAR) ? 32'd0 : r_ls;
            m_ni[node_wa] <= (i_cmd == lcdp_pkg::CMD_CLEAR) ? 64'd0 : r_li;
        end
        r_nd_s <= m_ns[r_k[NAW-1:0]];
        r_nd_i <= m_ni[r_k[NAW-1:0]];
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lcdp_pkg::CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // main datapath sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rbest  <= lcdp_pkg::MOST_NEG;
            r_clr    <= '0;
            r_sp     <= '0;
            r_pass   <= 1'b0;
            r_pt     <= '0;
            r_l      <= '0;
            r_r      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= (i_cmd == lcdp_pkg::CMD_WX);
            case (i_cmd)
                lcdp_pkg::CMD_CLR_GO: begin
                    r_clr   <= '0;
                    r_rbest <= lcdp_pkg::MOST_NEG;
                end
                lcdp_pkg::CMD_CLEAR: begin
                    r_clr   <= r_clr + NAW'(1);
                    r_rbest <= lcdp_pkg::MOST_NEG;
                end
                lcdp_pkg::CMD_ITEM: begin
                    r_x     <= i_position;
                    r_w     <= i_weight;
                    r_bonus <= i_bonus;
                    r_rank  <= rank_sat;
                    r_n     <= n_size;
                    r_k     <= KW'(1);
                    r_l     <= '0;
                    r_r     <= LW'(n_size - NW'(1));
                    r_best  <= lcdp_pkg::MOST_NEG;
                end
                lcdp_pkg::CMD_Q_MUL: begin
                    r_prod <= m_p;
                end
                lcdp_pkg::CMD_Q_ADD: begin
                    if (!lcdp_pkg::sge(r_best, q_v)) r_best <= q_v;
                    if (r_l < r_r) begin
                        r_k <= q_next_k;
                        if (r_rank <= mid) r_r <= mid;
                        else               r_l <= mid_p1[LW-1:0];
                    end
                end
                lcdp_pkg::CMD_FIN: begin
                    r_dp   <= n_dp;
                    r_prod <= m_p;
                    if (!lcdp_pkg::sge(r_rbest, n_dp)) r_rbest <= n_dp;
                end
                lcdp_pkg::CMD_WX: begin
                    // first insert: rising line on leaves up to rank
                    r_wx   <= r_prod;
                    r_k    <= KW'(1);
                    r_l    <= '0;
                    r_r    <= LW'(r_n - NW'(1));
                    r_ls   <= {1'b0, r_w};
                    r_li   <= r_dp - r_prod;
                    r_i    <= '0;
                    r_j    <= r_rank;
                    r_pass <= 1'b0;
                    r_sp   <= '0;
                end
                lcdp_pkg::CMD_I_NODE: begin
                    if (!o_stat.ins_skip && !o_stat.ins_cover && !o_stat.ins_leaf) begin
                        r_stk[r_sp[SAW-1:0]] <= push_f;
                        r_sp <= r_sp + SPW'(1);
                        r_k  <= k2;
                        r_r  <= mid;
                    end
                end
                lcdp_pkg::CMD_C2: begin
                    r_xp[0] <= xa;
                    r_xp[1] <= xb;
                end
                lcdp_pkg::CMD_C3: begin
                    r_xp[2] <= xa;
                    r_xp[3] <= xb;
                    r_os    <= r_nd_s;
                    r_oi    <= r_nd_i;
                    r_pt    <= '0;
                end
                lcdp_pkg::CMD_E_MO: begin
                    r_prod <= m_p;
                end
                lcdp_pkg::CMD_E_MN: begin
                    r_oval <= r_prod + r_oi;
                    r_prod <= m_p;
                end
                lcdp_pkg::CMD_E_CMP: begin
                    r_ge[r_pt] <= lcdp_pkg::sge(r_oval, n_nval);
                    r_le[r_pt] <= lcdp_pkg::sle(r_oval, n_nval);
                    r_pt       <= r_pt + 2'd1;
                end
                lcdp_pkg::CMD_I_DEC: begin
                    case (dec)
                        lcdp_pkg::DEC_RIGHT: begin
                            r_k <= k2p1;
                            r_l <= mid_p1[LW-1:0];
                        end
                        lcdp_pkg::DEC_RIGHT_SWAP: begin
                            r_k  <= k2p1;
                            r_l  <= mid_p1[LW-1:0];
                            r_ls <= r_os;
                            r_li <= r_oi;
                        end
                        lcdp_pkg::DEC_LEFT: begin
                            r_k <= k2;
                            r_r <= mid;
                        end
                        lcdp_pkg::DEC_LEFT_SWAP: begin
                            r_k  <= k2;
                            r_r  <= mid;
                            r_ls <= r_os;
                            r_li <= r_oi;
                        end
                        lcdp_pkg::DEC_SPLIT: begin
                            r_stk[r_sp[SAW-1:0]] <= push_f;
                            r_sp <= r_sp + SPW'(1);
                            r_k  <= k2;
                            r_r  <= mid;
                        end
                        default: begin
                            r_k <= r_k;
                        end
                    endcase
                end
                lcdp_pkg::CMD_POP: begin
                    if (r_sp != '0) begin
                        r_sp <= sp_m1;
                        r_k  <= pop_f.k;
                        r_l  <= pop_f.l;
                        r_r  <= pop_f.r;
                        r_ls <= pop_f.s;
                        r_li <= pop_f.i;
                    end else if (!r_pass) begin
                        // second insert: falling line on leaves from rank up
                        r_pass <= 1'b1;
                        r_k    <= KW'(1);
                        r_l    <= '0;
                        r_r    <= LW'(r_n - NW'(1));
                        r_ls   <= 32'd0 - {1'b0, r_w};
                        r_li   <= r_dp + r_wx;
                        r_i    <= r_rank;
                        r_j    <= LW'(r_n - NW'(1));
                    end
                end
                default: begin
                    r_pt <= r_pt;
                end
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_dp_value    = r_dp;
    assign o_best_so_far = r_rbest;

    // checks
    `LCDP_ASSERT_IMP(a_stack_bound, i_clk, i_rst_n, 1'b1, r_sp <= SPW'(lcdp_pkg::STK_DEPTH))
    `LCDP_ASSERT_NXT(a_strobe_pulse, i_clk, i_rst_n, r_ovalid, !r_ovalid)
    `LCDP_ASSERT_IMP(a_all_points, i_clk, i_rst_n, i_cmd == lcdp_pkg::CMD_I_DEC, r_pt == 2'd0)
    `LCDP_ASSERT_IMP(a_range_order, i_clk, i_rst_n, 1'b1, r_l <= r_r)

endmodule

// File: rtl/li_chao_distance_penalty_dp.sv
`timescale 1ns / 1ps
// Channel   Direction  Signals                                             Beat taken when
// item      in         i_start, o_busy, i_action, i_slot, i_sorted_coordinate,
//                      i_position, i_weight, i_bonus, i_rank               i_start & !o_busy
// result    out        o_valid, o_dp_value, o_best_so_far                  o_valid (one cycle)
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_data                i_cfg_valid & o_cfg_ready
//
// A load or an unused action leaves the block idle. A process item takes its beat, then a
// read, a multiply and an add per query tree level (up to eleven levels), then the sum and the
// slope product; the result beat follows. Two range inserts then run, one step per split,
// skipped or leaf node and per stack pop; a covered node reads four coordinates and forms
// eight products on the one 32x32 multiplier. Reset and clear zero the 4096-entry line store;
// reset is synchronous, active low. The result side cannot stall; one item at a time.
module li_chao_distance_penalty_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [1:0]                        i_action,
    input  logic [lcdp_pkg::LW-1:0]           i_slot,
    input  logic signed [31:0]                i_sorted_coordinate,
    input  logic signed [31:0]                i_position,
    input  logic [30:0]                       i_weight,
    input  logic signed [31:0]                i_bonus,
    input  logic [lcdp_pkg::LW-1:0]           i_rank,
    output logic                              o_valid,
    output logic signed [63:0]                o_dp_value,
    output logic signed [63:0]                o_best_so_far,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lcdp_pkg::CFG_W-1:0]        i_cfg_data
);

    lcdp_pkg::t_cmd  cmd;
    lcdp_pkg::t_stat stat;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    lcdp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_action (i_action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    lcdp_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_slot              (i_slot),
        .i_sorted_coordinate (i_sorted_coordinate),
        .i_position          (i_position),
        .i_weight            (i_weight),
        .i_bonus             (i_bonus),
        .i_rank              (i_rank),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_data          (i_cfg_data),
        .o_stat              (stat),
        .o_valid             (o_valid),
        .o_dp_value          (o_dp_value),
        .o_best_so_far       (o_best_so_far)
    );

endmodule
